/* rtl/core/tar_pkg.sv */
// Shared types and constants for the aging-replacement TLB core.
// No dependencies; imported by tar_ctrl, tar_dpath, tlb_aging_replacement_core and the verif files.
package tar_pkg;

  // Fixed field widths of the request and response words and the age counters
  localparam int CMD_W   = 2;
  localparam int PID_W   = 8;
  localparam int ADDR_W  = 32;
  localparam int FRAME_W = 20;
  localparam int AGE_W   = 8;

  // Defaults for the top-level parameters
  localparam int TAR_ENTRIES     = 32;
  localparam int TAR_OFFSET_BITS = 12;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INVAL  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // Age counter constants
  localparam logic [AGE_W-1:0] AGE_TOP = 8'h80;
  localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [PID_W-1:0]   proc_id;
    logic [ADDR_W-1:0]  virt_addr;
    logic [FRAME_W-1:0] frame_in;
  } tar_in_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame_out;
  } tar_out_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load_req;     // latch the accepted request word
    logic capture;      // register the tag compare vectors
    logic select;       // resolve hit / victim, update ages or valids
    logic scan_step;    // one step of the lowest-age scan
    logic write_entry;  // write the victim entry
    logic load_out;     // load the response register
  } tar_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             any_free;
    logic             scan_last;
  } tar_sts_t;

endpackage

/* rtl/core/tlb_aging_replacement_core.sv */
// Top level of the fully associative TLB with aging-counter replacement.
// Depends on tar_pkg, tar_ctrl and tar_dpath.
//
//   Channel  Dir  Handshake           Word
//   in_      in   in_valid/in_stall   tar_in_t  {cmd, proc_id, virt_addr, frame_in}
//   out_     out  out_valid/out_stall tar_out_t {hit, frame_out}
//
// One word in flight at a time; a result waiting in the output register does
// not hold off the next word. Search, invalidate and unused commands pass
// through latch, tag compare, select and response; a store adds an entry
// write, preceded when the table is full by the one-entry-per-cycle
// lowest-age scan. Reset is synchronous and clears valid bits and ages at once.
// in_stall is high from acceptance until the result is loaded.
module tlb_aging_replacement_core
  import tar_pkg::*;
#(
  parameter int ENTRIES     = TAR_ENTRIES,
  parameter int OFFSET_BITS = TAR_OFFSET_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tar_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output tar_out_t out_word
);

  tar_cmd_t cmd;
  tar_sts_t sts;

  // Sequencer
  tar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and compare datapath
  tar_dpath #(
    .ENTRIES     (ENTRIES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule

/* rtl/core/tar_ctrl.sv */
// Sequencing state machine for the TLB core: handshakes and datapath commands.
// Depends on tar_pkg.
module tar_ctrl
  import tar_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  tar_sts_t sts,
  output tar_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SEL,
    ST_SCAN,
    ST_WR,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept    = in_valid && !in_stall_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_stall_nxt  = in_stall_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_req = 1'b1;
          in_stall_nxt = 1'b1;
          state_nxt    = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.capture = 1'b1;
        state_nxt   = ST_SEL;
      end
      ST_SEL: begin
        cmd.select = 1'b1;
        if (sts.op == CMD_STORE) begin
          state_nxt = sts.any_free ? ST_WR : ST_SCAN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        cmd.write_entry = 1'b1;
        state_nxt       = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          in_stall_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input is only taken with the sequencer at rest
  a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall_r |-> state_r == ST_IDLE)
    else $error("input open while sequencer busy");

  // A response is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("response register overwritten");

  // Every accepted word reaches the compare step next
  a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_CMP)
    else $error("accepted word not processed");

endmodule

/* rtl/core/tar_dpath.sv */
// Datapath of the TLB core: tag CAM, age counters, frame memory, victim scan,
// response register. Depends on tar_pkg.
module tar_dpath
  import tar_pkg::*;
#(
  parameter int ENTRIES     = TAR_ENTRIES,
  parameter int OFFSET_BITS = TAR_OFFSET_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  tar_in_t  in_word,
  input  tar_cmd_t cmd,
  output tar_sts_t sts,
  output tar_out_t out_word
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PAGE_W = ADDR_W - OFFSET_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  tar_in_t            req_r;
  logic [PAGE_W-1:0]  req_page;

  logic [ENTRIES-1:0] valid_r;
  logic [PID_W-1:0]   pid_r   [ENTRIES];
  logic [PAGE_W-1:0]  page_r  [ENTRIES];
  logic [AGE_W-1:0]   age_r   [ENTRIES];
  logic [FRAME_W-1:0] frame_mem_r [ENTRIES];

  logic [ENTRIES-1:0] hit_vec, pidm_vec;
  logic [ENTRIES-1:0] hit_vec_r, pidm_vec_r, free_vec_r;
  logic [IDX_W-1:0]   hit_idx, free_idx;
  logic               any_hit, any_free;

  logic               hit_r;
  logic [FRAME_W-1:0] frame_q_r;
  logic [IDX_W-1:0]   victim_r;
  logic [IDX_W-1:0]   scan_idx_r;
  logic [AGE_W-1:0]   low_r;
  logic [AGE_W-1:0]   scan_age;
  logic               do_age;
  tar_out_t           out_r;

  assign req_page = req_r.virt_addr[ADDR_W-1:OFFSET_BITS];
  assign any_hit  = |hit_vec_r;
  assign any_free = |free_vec_r;
  assign do_age   = cmd.select && (req_r.cmd == CMD_SEARCH) && any_hit;
  assign scan_age = age_r[scan_idx_r];

  assign sts.op        = req_r.cmd;
  assign sts.any_free  = any_free;
  assign sts.scan_last = (scan_idx_r == LAST_IDX);
  assign out_word      = out_r;

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_word;
    end
  end

  // Parallel tag compare across all entries
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      pidm_vec[i] = (pid_r[i] == req_r.proc_id);
      hit_vec[i]  = valid_r[i] && pidm_vec[i] && (page_r[i] == req_page);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit_vec_r  <= hit_vec;
      pidm_vec_r <= pidm_vec;
      free_vec_r <= ~valid_r;
    end
  end

  // Lowest-index hit and lowest-index free entry
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec_r[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (free_vec_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // Valid bits: set on entry write, cleared by process invalidate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.select && (req_r.cmd == CMD_INVAL)) begin
      valid_r <= valid_r & ~pidm_vec_r;
    end else if (cmd.write_entry) begin
      valid_r[victim_r] <= 1'b1;
    end
  end

  // Tag storage
  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      pid_r[victim_r]  <= req_r.proc_id;
      page_r[victim_r] <= req_page;
    end
  end

  // Age counters: all shift on a hit, hit entry gets the top bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else if (do_age) begin
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= (age_r[i] >> 1) | ((hit_idx == IDX_W'(i)) ? AGE_TOP : '0);
      end
    end
  end

  // Frame memory, registered read at the hit index
  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      frame_mem_r[victim_r] <= req_r.frame_in;
    end
    if (cmd.select) begin
      frame_q_r <= frame_mem_r[hit_idx];
    end
  end

  // Hit flag and victim selection / lowest-age scan
  always_ff @(posedge clk) begin
    if (cmd.select) begin
      hit_r      <= (req_r.cmd == CMD_SEARCH) && any_hit;
      victim_r   <= any_free ? free_idx : '0;
      low_r      <= AGE_MAX;
      scan_idx_r <= '0;
    end else if (cmd.scan_step) begin
      if (scan_age < low_r) begin
        low_r    <= scan_age;
        victim_r <= scan_idx_r;
      end
      scan_idx_r <= scan_idx_r + 1'b1;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.hit       <= hit_r;
      out_r.frame_out <= hit_r ? frame_q_r : '0;
    end
  end

  // The victim picked from the free list is really free
  a_free_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.select && (req_r.cmd == CMD_STORE) && any_free) |=> !valid_r[victim_r])
    else $error("free victim already valid");

  // A written entry is valid afterwards
  a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_entry |=> valid_r[$past(victim_r)])
    else $error("written entry not valid");

  // A search hit leaves the hit entry with the top age bit set
  a_age_top: assert property (@(posedge clk) disable iff (!rst_n)
    do_age |=> age_r[$past(hit_idx)][AGE_W-1])
    else $error("hit entry age not refreshed");

endmodule

/* verif/tar_translation_checker.sv */
`timescale 1ns / 100ps
// Checker for the aging-replacement TLB core: keeps a shadow copy of the table
// and compares each result word, in order, with the prediction. Depends on tar_pkg.
module tar_translation_checker
  import tar_pkg::*;
#(
  parameter int ENTRIES     = TAR_ENTRIES,
  parameter int OFFSET_BITS = TAR_OFFSET_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  tar_in_t  in_word,
  input  logic     out_valid,
  input  logic     out_stall,
  input  tar_out_t out_word,
  output int       mismatches,
  output int       pending,
  output int       hits_seen,
  output int       replacements
);
  localparam int PAGE_W = ADDR_W - OFFSET_BITS;

  // Shadow table
  logic               shadow_valid [ENTRIES];
  logic [PID_W-1:0]   shadow_pid   [ENTRIES];
  logic [PAGE_W-1:0]  shadow_page  [ENTRIES];
  logic [FRAME_W-1:0] shadow_frame [ENTRIES];
  logic [AGE_W-1:0]   shadow_age   [ENTRIES];

  tar_out_t expected_xlat [$];
  tar_out_t want;
  int       miss_count  = 0;
  int       hit_count   = 0;
  int       evict_count = 0;

  // Apply one request word to the shadow table and return the result it causes
  function automatic tar_out_t translate_and_update(input tar_in_t w);
    tar_out_t          res;
    logic [PAGE_W-1:0] page;
    logic [AGE_W-1:0]  low_age;
    int                slot;
    res     = '0;
    page    = w.virt_addr[ADDR_W-1:OFFSET_BITS];
    slot    = -1;
    low_age = AGE_MAX;
    case (w.cmd)
      // lowest valid match wins; all ages decay, the winner gets the top bit
      CMD_SEARCH: begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && shadow_valid[i] && shadow_pid[i] == w.proc_id &&
              shadow_page[i] == page)
            slot = i;
        if (slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++) shadow_age[i] = shadow_age[i] >> 1;
          shadow_age[slot] = shadow_age[slot] | AGE_TOP;
          res.hit       = 1'b1;
          res.frame_out = shadow_frame[slot];
          hit_count++;
        end
      end
      // first free entry; when full, first lowest age below saturation, else entry 0
      CMD_STORE: begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !shadow_valid[i]) slot = i;
        if (slot < 0) begin
          evict_count++;
          slot = 0;
          for (int i = 0; i < ENTRIES; i++)
            if (shadow_age[i] < low_age) begin
              low_age = shadow_age[i];
              slot    = i;
            end
        end
        shadow_valid[slot] = 1'b1;
        shadow_pid[slot]   = w.proc_id;
        shadow_page[slot]  = page;
        shadow_frame[slot] = w.frame_in;
      end
      // every entry carrying the pid goes invalid, valid or not
      CMD_INVAL: begin
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_pid[i] == w.proc_id) shadow_valid[i] = 1'b0;
      end
      // unused command: table untouched
      default: ;
    endcase
    return res;
  endfunction

  // Result side first: a word accepted this edge cannot answer one accepted now
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        shadow_valid[i] = 1'b0;
        shadow_pid[i]   = '0;
        shadow_page[i]  = '0;
        shadow_frame[i] = '0;
        shadow_age[i]   = '0;
      end
      expected_xlat.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_xlat.size() == 0) begin
          miss_count++;
          $display("%0t: result word with none expected: hit %0b frame %h",
                   $time, out_word.hit, out_word.frame_out);
        end else begin
          want = expected_xlat.pop_front();
          if (out_word.hit !== want.hit) begin
            miss_count++;
            $display("%0t: hit mismatch: expected %0b actual %0b",
                     $time, want.hit, out_word.hit);
          end
          if (out_word.frame_out !== want.frame_out) begin
            miss_count++;
            $display("%0t: frame_out mismatch: expected %h actual %h",
                     $time, want.frame_out, out_word.frame_out);
          end
        end
      end
      if (in_valid && !in_stall) expected_xlat.push_back(translate_and_update(in_word));
    end
    mismatches   <= miss_count;
    pending      <= expected_xlat.size();
    hits_seen    <= hit_count;
    replacements <= evict_count;
  end

endmodule

/* verif/tlb_aging_replacement_core_tb.sv */
`timescale 1ns / 100ps
// Testbench top for tlb_aging_replacement_core: clock, reset, request words,
// result-side stalls, watchdog and verdict. Depends on tar_pkg, the core RTL
// and tar_translation_checker.
module tlb_aging_replacement_core_tb;
  import tar_pkg::*;

  localparam int ENTRIES      = TAR_ENTRIES;
  localparam int OFFSET_BITS  = TAR_OFFSET_BITS;
  localparam int PAGE_W       = ADDR_W - OFFSET_BITS;
  localparam int RANDOM_WORDS = 700;
  localparam int PHASE_LEN    = 150;
  localparam int HOLD_CYCLES  = 80;
  localparam int QUIET_LIMIT  = 2000;
  localparam int KEEP_KEYS    = 40;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  tar_in_t  in_word   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  tar_out_t out_word;
  bit       no_idle   = 1'b0;

  int mismatches, pending, hits_seen, replacements;
  int cmd_count [4];  // accepted words per command code

  // Key pools keep pid and page collisions frequent
  logic [PID_W-1:0]  pid_pool   [6];
  logic [PAGE_W-1:0] page_pool  [48];
  logic [PID_W-1:0]  known_pid  [$];
  logic [PAGE_W-1:0] known_page [$];

  tlb_aging_replacement_core #(
    .ENTRIES    (ENTRIES),
    .OFFSET_BITS(OFFSET_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  tar_translation_checker #(
    .ENTRIES    (ENTRIES),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .mismatches  (mismatches),
    .pending     (pending),
    .hits_seen   (hits_seen),
    .replacements(replacements)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Offer one request word after a random gap, none in no-idle stretches, and hold it until accepted
  task automatic offer(input logic [CMD_W-1:0] op, input logic [PID_W-1:0] pid,
                       input logic [ADDR_W-1:0] addr, input logic [FRAME_W-1:0] frame);
    tar_in_t w;
    int      gap;
    w.cmd       = op;
    w.proc_id   = pid;
    w.virt_addr = addr;
    w.frame_in  = frame;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    cmd_count[op]++;
    if (op == CMD_STORE) begin
      known_pid.push_back(pid);
      known_page.push_back(addr[ADDR_W-1:OFFSET_BITS]);
      if (known_pid.size() > KEEP_KEYS) begin
        void'(known_pid.pop_front());
        void'(known_page.pop_front());
      end
    end
  endtask

  // Result side: random stall per word, two long hold-offs to back up the core
  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (taken == 100 || taken == 480) gap = HOLD_CYCLES;
      else if (no_idle) gap = 0;
      else gap = $urandom_range(0, 10);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
      taken++;
    end
  end

  // Watchdog: too long without any handshake ends the run
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: watchdog: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [CMD_W-1:0]       op;
    logic [PID_W-1:0]       pid;
    logic [PAGE_W-1:0]      page;
    logic [OFFSET_BITS-1:0] offs;
    int                     sel;
    int                     k;
    int                     words;
    int                     real_words;
    pid_pool[0]  = '0;
    pid_pool[1]  = '1;
    for (int i = 2; i < 6; i++) pid_pool[i] = PID_W'($urandom);
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < 48; i++) page_pool[i] = PAGE_W'($urandom);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: any search misses
    offer(CMD_SEARCH, 8'h00, 32'h0000_0000, 20'h00000);
    // extremes of pid, page, offset and frame
    offer(CMD_STORE,  8'h00, 32'h0000_0000, 20'hFFFFF);
    offer(CMD_SEARCH, 8'h00, 32'h0000_0FFF, 20'h00000);
    offer(CMD_STORE,  8'hFF, 32'hFFFF_FFFF, 20'h00000);
    offer(CMD_SEARCH, 8'hFF, 32'hFFFF_F000, 20'hFFFFF);
    // right page under the wrong pid, right pid on the wrong page
    offer(CMD_SEARCH, 8'h00, 32'hFFFF_FFFF, 20'h00000);
    offer(CMD_SEARCH, 8'hFF, 32'h0000_0000, 20'h00000);
    // duplicate mappings: the lower entry answers
    offer(CMD_STORE,  8'h5A, 32'h1234_5678, 20'hABCDE);
    offer(CMD_STORE,  8'h5A, 32'h1234_5000, 20'h13579);
    offer(CMD_SEARCH, 8'h5A, 32'h1234_5ABC, 20'h00000);
    // unused command with every field set changes nothing
    offer(CMD_NONE,   8'hFF, 32'hFFFF_FFFF, 20'hFFFFF);
    offer(CMD_SEARCH, 8'h5A, 32'h1234_5000, 20'hFFFFF);
    // invalidate drops both duplicates; the holes refill first
    offer(CMD_INVAL,  8'h5A, 32'h0000_0000, 20'h00000);
    offer(CMD_SEARCH, 8'h5A, 32'h1234_5000, 20'h00000);
    offer(CMD_STORE,  8'hA5, 32'hEDCB_A987, 20'h55555);
    offer(CMD_STORE,  8'h3C, 32'h0000_1000, 20'hAAAAA);
    offer(CMD_SEARCH, 8'hA5, 32'hEDCB_A000, 20'h00000);
    offer(CMD_SEARCH, 8'h3C, 32'h0000_1FFF, 20'h00000);
    // invalidate of an absent pid, then of pid zero
    offer(CMD_INVAL,  8'h33, 32'hFFFF_FFFF, 20'hFFFFF);
    offer(CMD_SEARCH, 8'hFF, 32'hFFFF_FABC, 20'h00000);
    offer(CMD_INVAL,  8'h00, 32'h0000_0000, 20'h00000);
    offer(CMD_SEARCH, 8'h00, 32'h0000_0000, 20'h00000);

    // Random part: even phases only fill and age the table, odd ones also invalidate
    words      = 0;
    real_words = 0;
    while (real_words < RANDOM_WORDS) begin
      no_idle = (words % PHASE_LEN) < 25;
      sel     = $urandom_range(0, 99);
      pid     = pid_pool[$urandom_range(0, 5)];
      page    = page_pool[$urandom_range(0, 47)];
      offs    = OFFSET_BITS'($urandom);
      if ($urandom_range(0, 4) == 0) pid = PID_W'($urandom);
      if ($urandom_range(0, 5) == 0) page = PAGE_W'($urandom);
      if (sel < 4) op = CMD_NONE;
      else if (sel < 10 && (words / PHASE_LEN) % 2 == 1) op = CMD_INVAL;
      else if (sel < 45) op = CMD_STORE;
      else begin
        op = CMD_SEARCH;
        // mostly look up a recent mapping
        if (known_pid.size() > 0 && $urandom_range(0, 9) < 7) begin
          k    = $urandom_range(0, known_pid.size() - 1);
          pid  = known_pid[k];
          page = known_page[k];
        end
      end
      offer(op, pid, {page, offs}, FRAME_W'($urandom));
      words++;
      if (op != CMD_NONE) real_words++;
    end
    in_valid <= 1'b0;
    no_idle  = 1'b0;

    // drain, then give a slow store time to show a stray word
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (ENTRIES + 10) @(posedge clk);

    $display("Run covered %0d searches (%0d hits), %0d stores (%0d into a full table),",
             cmd_count[CMD_SEARCH], hits_seen, cmd_count[CMD_STORE], replacements);
    $display("%0d invalidates and %0d unused commands, with two long result hold-offs.",
             cmd_count[CMD_INVAL], cmd_count[CMD_NONE]);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
